@@ design/rmt_pkg.sv @@
// Shared types and constants for the range maximum tree unit.
`timescale 1ns / 1ps

package rmt_pkg;

	localparam int LEAVES_DEF     = 1024;
	localparam int VALUE_BITS_DEF = 32;

	localparam int INDEX_W = 10;
	localparam int VALUE_W = 32;
	localparam int RANGE_W = 11;

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_QUERY  = 1'b1;

	typedef struct packed {
		logic               cmd;
		logic [INDEX_W-1:0] index;
		logic [VALUE_W-1:0] value;
		logic [RANGE_W-1:0] range_low;
		logic [RANGE_W-1:0] range_high;
	} rmt_req_t;

endpackage

@@ design/rmt_node_ram.sv @@
// Node storage: one write port, one registered read port, zeroing sweep after reset.
`timescale 1ns / 1ps

module rmt_node_ram #(
	parameter int AW = 11,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata,
	output logic          clr_busy
);

	localparam int DEPTH = 2 ** AW;

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;
	logic [AW-1:0] clr_cnt_q;
	logic          clr_busy_q;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [DW-1:0] mem_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
			if (clr_cnt_q == {AW{1'b1}}) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// sweep owns the write port until every entry holds zero
	assign mem_we    = clr_busy_q | we;
	assign mem_waddr = clr_busy_q ? clr_cnt_q : waddr;
	assign mem_wdata = clr_busy_q ? '0 : wdata;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata    = rdata_q;
	assign clr_busy = clr_busy_q;

endmodule

@@ design/rmt_ctrl.sv @@
// Sequencer: leaf-to-root update walk and bottom-up range max walk over node memory.
`timescale 1ns / 1ps

module rmt_ctrl #(
	parameter int LEAVES     = rmt_pkg::LEAVES_DEF,
	parameter int VALUE_BITS = rmt_pkg::VALUE_BITS_DEF,
	parameter int AW         = $clog2(LEAVES) + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  rmt_pkg::rmt_req_t     req,
	output logic                  res_valid,
	input  logic                  res_ready,
	output logic [VALUE_BITS-1:0] res_value,
	input  logic                  clr_busy,
	output logic                  we,
	output logic [AW-1:0]         waddr,
	output logic [VALUE_BITS-1:0] wdata,
	output logic                  re,
	output logic [AW-1:0]         raddr,
	input  logic [VALUE_BITS-1:0] rdata
);

	localparam int P   = 2 ** (AW - 1);
	localparam int LRW = AW + 1;
	localparam int CW  = (LRW > rmt_pkg::RANGE_W) ? LRW : rmt_pkg::RANGE_W;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_UWR  = 3'd1;
	localparam logic [2:0] ST_URD  = 3'd2;
	localparam logic [2:0] ST_QA   = 3'd3;
	localparam logic [2:0] ST_QB   = 3'd4;

	logic [2:0]            state_q, state_d;
	logic [AW-1:0]         node_q, node_d;
	logic [VALUE_BITS-1:0] acc_q, acc_d;
	logic [LRW-1:0]        l_q, l_d, r_q, r_d;
	logic                  pend_q, pend_d;
	logic [VALUE_BITS-1:0] fold;
	logic [CW-1:0]         lo_ext, hi_ext, lo_c, hi_c;

	always_comb begin
		lo_ext = CW'(req.range_low);
		hi_ext = CW'(req.range_high);
		lo_c   = (lo_ext > CW'(P)) ? CW'(P) : lo_ext;
		hi_c   = (hi_ext > CW'(P)) ? CW'(P) : hi_ext;
	end

	// a query read issued last cycle lands in rdata now
	assign fold = (pend_q && (rdata > acc_q)) ? rdata : acc_q;

	always_comb begin
		state_d   = state_q;
		node_d    = node_q;
		acc_d     = acc_q;
		l_d       = l_q;
		r_d       = r_q;
		pend_d    = 1'b0;
		we        = 1'b0;
		waddr     = node_q;
		wdata     = acc_q;
		re        = 1'b0;
		raddr     = '0;
		req_ready = 1'b0;
		res_valid = 1'b0;
		res_value = fold;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = !clr_busy;
				if (req_valid && !clr_busy) begin
					if (req.cmd == rmt_pkg::CMD_UPDATE) begin
						if (32'(req.index) < 32'(LEAVES)) begin
							node_d  = AW'(P) + AW'(req.index);
							acc_d   = VALUE_BITS'(req.value);
							state_d = ST_UWR;
						end
					end else begin
						l_d     = LRW'(lo_c) + LRW'(P);
						r_d     = LRW'(hi_c) + LRW'(P);
						acc_d   = '0;
						state_d = ST_QA;
					end
				end
			end
			ST_UWR: begin
				we = 1'b1;
				if (node_q == AW'(1)) begin
					state_d = ST_IDLE;
				end else begin
					re      = 1'b1;
					raddr   = node_q ^ AW'(1);
					state_d = ST_URD;
				end
			end
			ST_URD: begin
				acc_d   = (rdata > acc_q) ? rdata : acc_q;
				node_d  = node_q >> 1;
				state_d = ST_UWR;
			end
			ST_QA: begin
				acc_d = fold;
				if (l_q >= r_q) begin
					res_valid = 1'b1;
					if (res_ready) begin
						state_d = ST_IDLE;
					end
				end else begin
					if (l_q[0]) begin
						re     = 1'b1;
						raddr  = AW'(l_q);
						l_d    = l_q + LRW'(1);
						pend_d = 1'b1;
					end
					state_d = ST_QB;
				end
			end
			ST_QB: begin
				acc_d = fold;
				if (r_q[0]) begin
					re     = 1'b1;
					raddr  = AW'(r_q - LRW'(1));
					pend_d = 1'b1;
				end
				l_d     = l_q >> 1;
				r_d     = r_q >> 1;
				state_d = ST_QA;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		node_q <= node_d;
		acc_q  <= acc_d;
		l_q    <= l_d;
		r_q    <= r_d;
	end

	a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !req_ready)
		else $error("request taken during zeroing sweep");

	a_root_ends_update: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UWR && node_q == AW'(1)) |=> state_q == ST_IDLE)
		else $error("update walk did not stop at root");

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(we && re) |-> waddr != raddr)
		else $error("read and write hit the same node");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> res_valid && $stable(res_value))
		else $error("stalled result changed");

	a_pend_only_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (state_q == ST_QA || state_q == ST_QB))
		else $error("query read pending outside a query");

endmodule

@@ design/range_max_tree_unit.sv @@
// Top level of the range maximum tree unit: request channel, result register, node memory.
`timescale 1ns / 1ps
//
// Range maximum segment tree with point updates.
// Input channel (in_valid/in_ready): cmd selects an update (write value at leaf index,
// then refresh all ancestors) or a query (maximum over leaves [range_low, range_high)).
// Updates give no result; each query gives exactly one max_value on the output channel
// (out_valid/out_ready). Empty or out-of-range spans return 0; update indexes at or
// beyond LEAVES are dropped.
// With L = log2 of LEAVES rounded up to a power of two: an update writes one node per
// tree level from leaf to root on the node memory and reads the sibling at each level
// below the root; a query reads at most one node per side at each tree level, and its
// result is registered in the output register when the walk ends. The node memory has
// a single read port; one request is worked on at a time.
// The output register lets the next request be taken while a result waits; a query
// that finishes while the previous result is still unread holds until out_ready.
// Reset: after arst_n releases, a sweep zeroes all 2*2^L node entries, one per cycle
// (2048 entries at the default size); in_ready stays low during the sweep.
//

module range_max_tree_unit #(
	parameter int LEAVES     = rmt_pkg::LEAVES_DEF,
	parameter int VALUE_BITS = rmt_pkg::VALUE_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        cmd,
	input  logic [rmt_pkg::INDEX_W-1:0] index,
	input  logic [rmt_pkg::VALUE_W-1:0] value,
	input  logic [rmt_pkg::RANGE_W-1:0] range_low,
	input  logic [rmt_pkg::RANGE_W-1:0] range_high,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [rmt_pkg::VALUE_W-1:0] max_value
);

	localparam int AW = $clog2(LEAVES) + 1;
	localparam int OW = rmt_pkg::VALUE_W;

	rmt_pkg::rmt_req_t     req;
	logic                  res_valid;
	logic                  res_ready;
	logic [VALUE_BITS-1:0] res_value;
	logic                  clr_busy;
	logic                  we;
	logic [AW-1:0]         waddr;
	logic [VALUE_BITS-1:0] wdata;
	logic                  re;
	logic [AW-1:0]         raddr;
	logic [VALUE_BITS-1:0] rdata;
	logic                  out_valid_q;
	logic [OW-1:0]         max_value_q;

	always_comb begin
		req.cmd        = cmd;
		req.index      = index;
		req.value      = value;
		req.range_low  = range_low;
		req.range_high = range_high;
	end

	rmt_ctrl #(
		.LEAVES     (LEAVES),
		.VALUE_BITS (VALUE_BITS),
		.AW         (AW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (in_valid),
		.req_ready (in_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_value (res_value),
		.clr_busy  (clr_busy),
		.we        (we),
		.waddr     (waddr),
		.wdata     (wdata),
		.re        (re),
		.raddr     (raddr),
		.rdata     (rdata)
	);

	rmt_node_ram #(
		.AW (AW),
		.DW (VALUE_BITS)
	) u_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (we),
		.waddr    (waddr),
		.wdata    (wdata),
		.re       (re),
		.raddr    (raddr),
		.rdata    (rdata),
		.clr_busy (clr_busy)
	);

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			max_value_q <= OW'(res_value);
		end
	end

	assign out_valid = out_valid_q;
	assign max_value = max_value_q;

endmodule

@@ bench/range_max_tree_checker.sv @@
// Checker for the range maximum tree unit: tracks leaf values and scores every query result.
`timescale 1ns / 1ps

module range_max_tree_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic                        cmd,
	input  logic [rmt_pkg::INDEX_W-1:0] index,
	input  logic [rmt_pkg::VALUE_W-1:0] value,
	input  logic [rmt_pkg::RANGE_W-1:0] range_low,
	input  logic [rmt_pkg::RANGE_W-1:0] range_high,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [rmt_pkg::VALUE_W-1:0] max_value,
	output int                          mismatches,
	output int                          pending
);

	localparam int LEAVES     = rmt_pkg::LEAVES_DEF;
	localparam int PAD_LEAVES = 1 << $clog2(LEAVES);

	logic [rmt_pkg::VALUE_W-1:0] leaf_val [PAD_LEAVES];
	logic [rmt_pkg::VALUE_W-1:0] expected_max [$];
	int                          result_num;

	// padding leaves stay at zero, so clamping to the padded count is enough
	function automatic logic [rmt_pkg::VALUE_W-1:0] span_max(
		input logic [rmt_pkg::RANGE_W-1:0] lo_in,
		input logic [rmt_pkg::RANGE_W-1:0] hi_in);
		int                          lo;
		int                          hi;
		logic [rmt_pkg::VALUE_W-1:0] best;
		lo   = (lo_in > PAD_LEAVES) ? PAD_LEAVES : lo_in;
		hi   = (hi_in > PAD_LEAVES) ? PAD_LEAVES : hi_in;
		best = '0;
		for (int i = lo; i < hi; i++) begin
			if (leaf_val[i] > best)
				best = leaf_val[i];
		end
		return best;
	endfunction

	task automatic note_mismatch(input string what, input logic [rmt_pkg::VALUE_W-1:0] want,
	                             input logic [rmt_pkg::VALUE_W-1:0] got);
		$display("[%0t] result %0d: %s, expected %h got %h", $realtime, result_num, what,
		         want, got);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PAD_LEAVES; i++)
				leaf_val[i] = '0;
			expected_max.delete();
		end else begin
			// results leaving now belong to queries taken at earlier edges
			if (out_valid && out_ready) begin
				if (expected_max.size() == 0) begin
					note_mismatch("unexpected result", '0, max_value);
				end else begin
					if (max_value !== expected_max[0])
						note_mismatch("max_value", expected_max[0], max_value);
					void'(expected_max.pop_front());
				end
				result_num++;
			end
			if (in_valid && in_ready) begin
				if (cmd == rmt_pkg::CMD_UPDATE) begin
					if (index < LEAVES)
						leaf_val[index] = value;
				end else begin
					expected_max.push_back(span_max(range_low, range_high));
				end
			end
			pending = expected_max.size();
		end
	end

endmodule

@@ bench/range_max_tree_unit_tb.sv @@
// Testbench top for the range maximum tree unit: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module range_max_tree_unit_tb;

	localparam int RANDOM_ITEMS = 1750;
	localparam int HOLD_CYCLES  = 600;
	localparam int CYCLE_LIMIT  = 500000;
	localparam int TAIL_CYCLES  = 60;

	logic                        clk;
	logic                        arst_n;
	logic                        in_valid;
	logic                        in_ready;
	logic                        cmd;
	logic [rmt_pkg::INDEX_W-1:0] index;
	logic [rmt_pkg::VALUE_W-1:0] value;
	logic [rmt_pkg::RANGE_W-1:0] range_low;
	logic [rmt_pkg::RANGE_W-1:0] range_high;
	logic                        out_valid;
	logic                        out_ready;
	logic [rmt_pkg::VALUE_W-1:0] max_value;

	int mismatches;
	int pending;
	int cycle_count;
	bit idle_on;
	bit hold_go;
	bit rx_hold;

	range_max_tree_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.index      (index),
		.value      (value),
		.range_low  (range_low),
		.range_high (range_high),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.max_value  (max_value)
	);

	range_max_tree_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.index      (index),
		.value      (value),
		.range_low  (range_low),
		.range_high (range_high),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.max_value  (max_value),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// result side: random stalls, plus one long hold-off
	always @(negedge clk) begin
		if (rx_hold)
			out_ready <= 1'b0;
		else if (idle_on && $urandom_range(99) < 12)
			out_ready <= 1'b0;
		else
			out_ready <= 1'b1;
	end

	initial begin
		wait (hold_go);
		@(posedge clk);
		rx_hold = 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold = 1'b0;
	end

	// returns just after the edge that took the request
	task automatic send_request(input logic c, input logic [rmt_pkg::INDEX_W-1:0] idx,
	                            input logic [rmt_pkg::VALUE_W-1:0] val,
	                            input logic [rmt_pkg::RANGE_W-1:0] lo,
	                            input logic [rmt_pkg::RANGE_W-1:0] hi);
		@(negedge clk);
		while (idle_on && $urandom_range(99) < 12) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= c;
		index      <= idx;
		value      <= val;
		range_low  <= lo;
		range_high <= hi;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// fields that the command ignores get random junk
	task automatic send_update(input logic [rmt_pkg::INDEX_W-1:0] idx,
	                           input logic [rmt_pkg::VALUE_W-1:0] val);
		send_request(rmt_pkg::CMD_UPDATE, idx, val, rmt_pkg::RANGE_W'($urandom),
		             rmt_pkg::RANGE_W'($urandom));
	endtask

	task automatic send_query(input logic [rmt_pkg::RANGE_W-1:0] lo,
	                          input logic [rmt_pkg::RANGE_W-1:0] hi);
		send_request(rmt_pkg::CMD_QUERY, rmt_pkg::INDEX_W'($urandom), $urandom, lo, hi);
	endtask

	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	initial begin
		int                          pick;
		int                          lo;
		int                          hi;
		logic [rmt_pkg::INDEX_W-1:0] idx;
		logic [rmt_pkg::VALUE_W-1:0] val;

		arst_n     = 1'b0;
		in_valid   = 1'b0;
		cmd        = rmt_pkg::CMD_UPDATE;
		index      = '0;
		value      = '0;
		range_low  = '0;
		range_high = '0;
		idle_on    = 1'b1;

		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// directed: empty tree, extreme leaves and values, clamped and empty spans
		send_query(0, 1024);
		send_update(0, 32'hFFFF_FFFF);
		send_update(1023, 32'h0000_0001);
		send_update(512, 32'h8000_0000);
		send_update(511, 32'h7FFF_FFFF);
		send_update(1022, 32'h0000_0000);
		send_query(0, 1);
		send_query(1, 1024);
		send_query(1023, 1024);
		send_query(1023, 2047);
		send_query(1024, 2047);
		send_query(2047, 2047);
		send_query(5, 3);
		send_query(0, 0);
		send_query(512, 513);
		send_query(511, 512);
		send_query(0, 2047);
		send_query(1, 511);
		send_request(rmt_pkg::CMD_QUERY, 10'h3FF, 32'hFFFF_FFFF, 11'd1022, 11'd1023);
		send_request(rmt_pkg::CMD_UPDATE, 10'd0, 32'h0000_0000, 11'h7FF, 11'h000);
		send_query(0, 1024);
		drain_results();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 400)
				hold_go = 1'b1;
			if (n == 800)
				idle_on = 1'b0;
			if (n == 1100)
				idle_on = 1'b1;
			if (n == 1400)
				drain_results();
			pick = $urandom_range(99);
			if (pick < 40) begin
				if ($urandom_range(3) == 0)
					idx = rmt_pkg::INDEX_W'($urandom_range(15) + 100);
				else
					idx = rmt_pkg::INDEX_W'($urandom);
				case ($urandom_range(3))
					0: val = $urandom;
					1: val = rmt_pkg::VALUE_W'($urandom_range(255));
					2: val = 32'hFFFF_FFFF - rmt_pkg::VALUE_W'($urandom_range(3));
					default: val = '0;
				endcase
				send_update(idx, val);
			end else if (pick < 90) begin
				lo = $urandom_range(1023);
				if ($urandom_range(1) == 0)
					hi = lo + $urandom_range(16, 1);
				else
					hi = lo + $urandom_range(1024, 1);
				if (hi > 1024)
					hi = 1024;
				send_query(rmt_pkg::RANGE_W'(lo), rmt_pkg::RANGE_W'(hi));
			end else begin
				send_query(rmt_pkg::RANGE_W'($urandom_range(2047)),
				           rmt_pkg::RANGE_W'($urandom_range(2047)));
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
